[src/lcdfb_pkg.sv]
package lcdfb_pkg;

  localparam int LINE_LENGTH = 16;
  localparam int CELLS       = 2 * LINE_LENGTH;
  localparam int CUR_W       = $clog2(CELLS);
  localparam int PC_W        = 4;

  typedef logic [CUR_W-1:0] cell_idx_t;
  typedef logic [PC_W-1:0]  pc_t;

  localparam logic [7:0] LCD_HOME   = 8'h02;
  localparam logic [7:0] LCD_LINE2  = 8'h80 | 8'h40;
  localparam logic [7:0] SPACE_CHAR = 8'h20;

  typedef enum logic [2:0] {
    CMD_WRITE   = 3'd0,
    CMD_BACK    = 3'd1,
    CMD_NEWLINE = 3'd2,
    CMD_GOTO    = 3'd3,
    CMD_CLEAR   = 3'd4,
    CMD_REFRESH = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    EM_NONE  = 2'd0,
    EM_HOME  = 2'd1,
    EM_LINE2 = 2'd2,
    EM_DATA  = 2'd3
  } emit_t;

  typedef enum logic [1:0] {
    WR_NONE  = 2'd0,
    WR_CHAR  = 2'd1,
    WR_SPACE = 2'd2,
    WR_CLEAR = 2'd3
  } wr_t;

  typedef enum logic [2:0] {
    CUR_HOLD    = 3'd0,
    CUR_INC     = 3'd1,
    CUR_BACK    = 3'd2,
    CUR_NEWLINE = 3'd3,
    CUR_GOTO    = 3'd4,
    CUR_ZERO    = 3'd5
  } cur_op_t;

  typedef enum logic [1:0] {
    IDX_HOLD = 2'd0,
    IDX_CLR  = 2'd1,
    IDX_INC  = 2'd2
  } idx_op_t;

  typedef enum logic [1:0] {
    J_NEXT = 2'd0,
    J_GO   = 2'd1,
    J_LOOP = 2'd2
  } jmp_t;

  localparam pc_t PC_IDLE    = 4'd0;
  localparam pc_t PC_WRITE   = 4'd1;
  localparam pc_t PC_BACK    = 4'd2;
  localparam pc_t PC_BLANK   = 4'd3;
  localparam pc_t PC_HOME    = 4'd4;
  localparam pc_t PC_L1      = 4'd5;
  localparam pc_t PC_L2CMD   = 4'd6;
  localparam pc_t PC_L2      = 4'd7;
  localparam pc_t PC_NEWLINE = 4'd8;
  localparam pc_t PC_GOTO    = 4'd9;
  localparam pc_t PC_CLEAR   = 4'd10;
  localparam pc_t PC_LAST    = PC_CLEAR;

  typedef struct packed {
    emit_t   emit;
    wr_t     wr;
    cur_op_t cur;
    idx_op_t idx;
    jmp_t    jmp;
    pc_t     target;
  } ucode_t;

  typedef struct packed {
    ucode_t uc;
    logic   go;
    logic   accept;
  } ctrl_t;

  typedef struct packed {
    logic out_free;
    logic loop_done;
  } stat_t;

  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    w = '{EM_NONE, WR_NONE, CUR_HOLD, IDX_HOLD, J_GO, PC_IDLE};
    case (pc)
      PC_WRITE:   w = '{EM_NONE,  WR_CHAR,  CUR_INC,     IDX_HOLD, J_GO,   PC_IDLE};
      PC_BACK:    w = '{EM_NONE,  WR_NONE,  CUR_BACK,    IDX_HOLD, J_NEXT, PC_IDLE};
      PC_BLANK:   w = '{EM_NONE,  WR_SPACE, CUR_HOLD,    IDX_HOLD, J_NEXT, PC_IDLE};
      PC_HOME:    w = '{EM_HOME,  WR_NONE,  CUR_HOLD,    IDX_CLR,  J_NEXT, PC_IDLE};
      PC_L1:      w = '{EM_DATA,  WR_NONE,  CUR_HOLD,    IDX_INC,  J_LOOP, PC_L2CMD};
      PC_L2CMD:   w = '{EM_LINE2, WR_NONE,  CUR_HOLD,    IDX_HOLD, J_NEXT, PC_IDLE};
      PC_L2:      w = '{EM_DATA,  WR_NONE,  CUR_HOLD,    IDX_INC,  J_LOOP, PC_IDLE};
      PC_NEWLINE: w = '{EM_NONE,  WR_NONE,  CUR_NEWLINE, IDX_HOLD, J_GO,   PC_IDLE};
      PC_GOTO:    w = '{EM_NONE,  WR_NONE,  CUR_GOTO,    IDX_HOLD, J_GO,   PC_IDLE};
      PC_CLEAR:   w = '{EM_NONE,  WR_CLEAR, CUR_ZERO,    IDX_HOLD, J_GO,   PC_IDLE};
      default:    w = '{EM_NONE,  WR_NONE,  CUR_HOLD,    IDX_HOLD, J_GO,   PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

[src/lcdfb_useq.sv]
module lcdfb_useq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic [2:0]          in_cmd,
  input  lcdfb_pkg::stat_t    st,
  output logic                in_tready,
  output lcdfb_pkg::ctrl_t    ctrl
);

  lcdfb_pkg::pc_t    pc_r, pc_nxt, entry;
  lcdfb_pkg::ucode_t uc;
  logic              accept, go;

  assign uc        = lcdfb_pkg::ucode_rom(pc_r);
  assign in_tready = (pc_r == lcdfb_pkg::PC_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign go        = (uc.emit == lcdfb_pkg::EM_NONE) || st.out_free;

  assign ctrl.uc     = uc;
  assign ctrl.go     = go && !in_tready;
  assign ctrl.accept = accept;

  always_comb begin
    unique case (lcdfb_pkg::cmd_t'(in_cmd))
      lcdfb_pkg::CMD_WRITE:   entry = lcdfb_pkg::PC_WRITE;
      lcdfb_pkg::CMD_BACK:    entry = lcdfb_pkg::PC_BACK;
      lcdfb_pkg::CMD_NEWLINE: entry = lcdfb_pkg::PC_NEWLINE;
      lcdfb_pkg::CMD_GOTO:    entry = lcdfb_pkg::PC_GOTO;
      lcdfb_pkg::CMD_CLEAR:   entry = lcdfb_pkg::PC_CLEAR;
      lcdfb_pkg::CMD_REFRESH: entry = lcdfb_pkg::PC_HOME;
      default:                entry = lcdfb_pkg::PC_IDLE;
    endcase
  end

  always_comb begin
    pc_nxt = pc_r;
    if (in_tready) begin
      if (accept) begin
        pc_nxt = entry;
      end
    end else if (go) begin
      unique case (uc.jmp)
        lcdfb_pkg::J_NEXT: pc_nxt = pc_r + 1'b1;
        lcdfb_pkg::J_GO:   pc_nxt = uc.target;
        lcdfb_pkg::J_LOOP: pc_nxt = st.loop_done ? uc.target : pc_r;
        default:           pc_nxt = lcdfb_pkg::PC_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= lcdfb_pkg::PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

`ifndef SYNTHESIS
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= lcdfb_pkg::PC_LAST)
    else $error("step counter out of program");

  a_refresh_entry: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_cmd == lcdfb_pkg::CMD_REFRESH |=> pc_r == lcdfb_pkg::PC_HOME)
    else $error("refresh did not enter home step");

  a_l2_exit: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r == lcdfb_pkg::PC_L2 && go && st.loop_done |=> pc_r == lcdfb_pkg::PC_IDLE)
    else $error("line 2 loop did not return to idle");
`endif

endmodule

[src/lcdfb_datapath.sv]
module lcdfb_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  lcdfb_pkg::ctrl_t  ctrl,
  input  logic [7:0]        in_char,
  input  logic [1:0]        in_row,
  input  logic [4:0]        in_column,
  input  logic              out_tready,
  output lcdfb_pkg::stat_t  st,
  output logic              out_tvalid,
  output logic [7:0]        out_tdata,
  output logic              out_tuser,
  output logic              out_tlast
);

  logic [7:0]           buf_r [lcdfb_pkg::CELLS];
  lcdfb_pkg::cell_idx_t cur_r, cur_nxt, idx_r, idx_nxt;
  logic [7:0]           char_r;
  logic [1:0]           row_r;
  logic [4:0]           col_r;
  logic                 out_valid_r, out_data_r, out_last_r;
  logic [7:0]           out_byte_r;
  logic [7:0]           rd;
  logic                 goto_ok, idx_end;
  lcdfb_pkg::cell_idx_t goto_pos;
  lcdfb_pkg::ucode_t    uc;

  assign uc = ctrl.uc;
  assign rd = buf_r[idx_r];

  assign idx_end      = (idx_r == lcdfb_pkg::cell_idx_t'(lcdfb_pkg::CELLS - 1));
  assign st.loop_done = (idx_r == lcdfb_pkg::cell_idx_t'(lcdfb_pkg::LINE_LENGTH - 1)) || idx_end;
  assign st.out_free  = !out_valid_r || out_tready;

  assign goto_ok  = (row_r <= 2'd1) && (int'(col_r) < lcdfb_pkg::LINE_LENGTH);
  assign goto_pos = lcdfb_pkg::cell_idx_t'(int'(row_r[0]) * lcdfb_pkg::LINE_LENGTH
                                           + int'(col_r));

  always_comb begin
    cur_nxt = cur_r;
    if (ctrl.go) begin
      unique case (uc.cur)
        lcdfb_pkg::CUR_HOLD: cur_nxt = cur_r;
        lcdfb_pkg::CUR_INC:
          cur_nxt = (cur_r == lcdfb_pkg::cell_idx_t'(lcdfb_pkg::CELLS - 1)) ? '0
                                                                          : cur_r + 1'b1;
        lcdfb_pkg::CUR_BACK:
          cur_nxt = (cur_r == '0) ? lcdfb_pkg::cell_idx_t'(lcdfb_pkg::CELLS - 1)
                                  : cur_r - 1'b1;
        lcdfb_pkg::CUR_NEWLINE:
          cur_nxt = (int'(cur_r) >= lcdfb_pkg::LINE_LENGTH) ? '0
                    : lcdfb_pkg::cell_idx_t'(lcdfb_pkg::LINE_LENGTH);
        lcdfb_pkg::CUR_GOTO: cur_nxt = goto_ok ? goto_pos : cur_r;
        lcdfb_pkg::CUR_ZERO: cur_nxt = '0;
        default:             cur_nxt = cur_r;
      endcase
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (ctrl.go) begin
      unique case (uc.idx)
        lcdfb_pkg::IDX_HOLD: idx_nxt = idx_r;
        lcdfb_pkg::IDX_CLR:  idx_nxt = '0;
        lcdfb_pkg::IDX_INC:  idx_nxt = idx_r + 1'b1;
        default:             idx_nxt = idx_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
      idx_r <= '0;
    end else begin
      cur_r <= cur_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      char_r <= in_char;
      row_r  <= in_row;
      col_r  <= in_column;
    end
  end

  // text buffer, zero at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lcdfb_pkg::CELLS; i++) begin
        buf_r[i] <= '0;
      end
    end else if (ctrl.go) begin
      unique case (uc.wr)
        lcdfb_pkg::WR_NONE:  ;
        lcdfb_pkg::WR_CHAR:  buf_r[cur_r] <= char_r;
        lcdfb_pkg::WR_SPACE: buf_r[cur_r] <= lcdfb_pkg::SPACE_CHAR;
        lcdfb_pkg::WR_CLEAR: begin
          for (int i = 0; i < lcdfb_pkg::CELLS; i++) begin
            buf_r[i] <= lcdfb_pkg::SPACE_CHAR;
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.go && uc.emit != lcdfb_pkg::EM_NONE) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.go) begin
      unique case (uc.emit)
        lcdfb_pkg::EM_NONE: ;
        lcdfb_pkg::EM_HOME: begin
          out_byte_r <= lcdfb_pkg::LCD_HOME;
          out_data_r <= 1'b0;
          out_last_r <= 1'b0;
        end
        lcdfb_pkg::EM_LINE2: begin
          out_byte_r <= lcdfb_pkg::LCD_LINE2;
          out_data_r <= 1'b0;
          out_last_r <= 1'b0;
        end
        lcdfb_pkg::EM_DATA: begin
          out_byte_r <= rd;
          out_data_r <= 1'b1;
          out_last_r <= idx_end;
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cur_r) < lcdfb_pkg::CELLS)
    else $error("cursor beyond buffer");

  a_last_is_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_data_r)
    else $error("last flag on a command byte");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_byte_r)
      && $stable(out_data_r) && $stable(out_last_r))
    else $error("stalled output changed");
`endif

endmodule

[src/char_lcd_framebuffer_controller.sv]
// channel | dir | tdata (low bit up)                               | tuser   | tlast
// in_     | in  | cmd[2:0] char_code[10:3] row[12:11] column[17:13] | -       | -
// out_    | out | bus_byte[7:0]                                    | is_data | last
//
// Each item is accepted in the idle step, then runs its program: write, newline,
// goto and clear return straight to idle; refresh emits 34 bus bytes, one per
// step; backspace steps back, writes a space, then refreshes. A stalled output
// holds the program on its current emit step.
// Reset: buffer all zeros, cursor at cell 0, no clearing pass.
module char_lcd_framebuffer_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // cmd, char_code, row, column, zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // bus_byte
  output logic        out_tuser,  // is_data
  output logic        out_tlast
);

  lcdfb_pkg::ctrl_t ctrl;
  lcdfb_pkg::stat_t st;

  lcdfb_useq u_useq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_cmd    (in_tdata[2:0]),
    .st        (st),
    .in_tready (in_tready),
    .ctrl      (ctrl)
  );

  lcdfb_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .in_char    (in_tdata[10:3]),
    .in_row     (in_tdata[12:11]),
    .in_column  (in_tdata[17:13]),
    .out_tready (out_tready),
    .st         (st),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
